@@ hdl/pump_lead_lag_controller_top_macros.svh @@
// Assertion macros shared by the pump lead/lag controller RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PUMP_LEAD_LAG_CONTROLLER_TOP_MACROS_SVH
`define PUMP_LEAD_LAG_CONTROLLER_TOP_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define PLLC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pllc assertion failed");

// Checks that a consequence holds in the cycle of its antecedent.
`define PLLC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pllc implication failed");

`endif

@@ hdl/pllc_pkg.sv @@
// Types and constants of the pump lead/lag controller.
// Depends on nothing; imported by pllc_front, pllc_back, the top level and the bench.
`default_nettype none

package pllc_pkg;

   localparam int NUM_PUMPS = 3;
   localparam int SUM_W     = 21;
   localparam int REM_W     = 16;
   localparam int HOUR_W    = 32;
   localparam int RECIP_W   = 22;
   localparam int LIMIT_W   = 16;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [1:0] SEL_A    = 2'd0;
   localparam logic [1:0] SEL_C    = 2'd2;
   localparam logic [1:0] SEL_NONE = 2'd3;

   localparam logic [2:0] MODE_NONE  = 3'd0;
   localparam logic [2:0] MODE_SMALL = 3'd1;
   localparam logic [2:0] MODE_LARGE = 3'd2;
   localparam logic [2:0] MODE_BOTH  = 3'd3;
   localparam logic [2:0] MODE_ALL   = 3'd4;

   localparam logic [1:0] CMD_UNKNOWN = 2'd0;
   localparam logic [1:0] CMD_RUN     = 2'd1;
   localparam logic [1:0] CMD_STOP    = 2'd2;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_MODE = 1'b1;

   localparam logic [15:0] STAT_RUN_FWD = 16'd1;
   localparam logic [15:0] STAT_RUN_REV = 16'd2;
   localparam logic [15:0] STAT_STOPPED = 16'd3;

   localparam logic [LIMIT_W-1:0] ROT_LIMIT_RESET = 16'd600;
   localparam logic [0:0] CSR_ROT_LIMIT = 1'b0;

   typedef struct packed {
      logic        req_type;
      logic [19:0] elapsed_ms;
      logic [15:0] status_a;
      logic [15:0] status_b;
      logic [15:0] status_c;
      logic        auto_a;
      logic        auto_b;
      logic        auto_c;
      logic [2:0]  mode_value;
   } pllc_req_type;

   typedef struct packed {
      logic [1:0] pump_id;
      logic       run_cmd;
      logic [1:0] active_pump;
      logic [2:0] mode_now;
      logic       last;
   } pllc_rsp_type;

   typedef struct packed {
      logic                 is_mode;
      logic [19:0]          elapsed_ms;
      logic [NUM_PUMPS-1:0] running;
      logic [NUM_PUMPS-1:0] avail;
      logic [2:0]           mode_value;
   } pllc_item_type;

endpackage

`default_nettype wire

@@ hdl/pllc_fifo.sv @@
// Small first-in first-out queue built from flip-flops.
// Depends on nothing; used for the decoded request queue and the result queue.
`default_nettype none

module pllc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0]  entry_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr, do_rd;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_ADDR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/pllc_front.sv @@
// Front part: accepts requests, classifies each pump's status and queues the result.
// Depends on pllc_pkg and pllc_fifo.
`default_nettype none

module pllc_front
   import pllc_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   output logic               full,
   input  wire pllc_req_type  req_payload,
   output logic               item_valid,
   output pllc_item_type      item,
   input  wire logic          item_pop
);

   localparam int ITEM_W = $bits(pllc_item_type);

   pllc_item_type         decoded;
   logic [ITEM_W-1:0]     head_bits;
   logic                  queue_empty;
   logic [15:0]           status [NUM_PUMPS];
   logic [NUM_PUMPS-1:0]  auto_flag;

   assign status[0]  = req_payload.status_a;
   assign status[1]  = req_payload.status_b;
   assign status[2]  = req_payload.status_c;
   assign auto_flag  = {req_payload.auto_c, req_payload.auto_b, req_payload.auto_a};

   always_comb begin
      decoded.is_mode    = (req_payload.req_type == REQ_MODE);
      decoded.elapsed_ms = req_payload.elapsed_ms;
      decoded.mode_value = req_payload.mode_value;
      for (int i = 0; i < NUM_PUMPS; i++) begin
         decoded.running[i] = (status[i] == STAT_RUN_FWD) || (status[i] == STAT_RUN_REV);
         decoded.avail[i]   = auto_flag[i] && ((status[i] == STAT_RUN_FWD) ||
                              (status[i] == STAT_RUN_REV) || (status[i] == STAT_STOPPED));
      end
   end

   pllc_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (decoded),
      .full    (full),
      .rd_en   (item_pop),
      .rd_data (head_bits),
      .empty   (queue_empty)
   );

   assign item_valid = !queue_empty;
   assign item       = pllc_item_type'(head_bits);

endmodule

`default_nettype wire

@@ hdl/pllc_back.sv @@
// Back part: meters run time, picks and rotates the active pump, applies the
// mode fallback and emits changed commands. Depends on pllc_pkg and the macros.
`default_nettype none
`include "pump_lead_lag_controller_top_macros.svh"

module pllc_back
   import pllc_pkg::*;
#(
   parameter int MS_PER_CENTIHOUR = 36000
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [LIMIT_W-1:0]  rot_limit,
   input  wire logic                item_valid,
   input  wire pllc_item_type       item,
   output logic                     item_pop,
   output logic                     rsp_push,
   output pllc_rsp_type             rsp_data,
   input  wire logic                rsp_full
);

   localparam int PROD_W = SUM_W + RECIP_W;
   localparam int FIX_W  = REM_W + 1;
   localparam logic [REM_W-1:0]   DIV   = REM_W'(MS_PER_CENTIHOUR);
   localparam logic [FIX_W-1:0]   DIV_X = FIX_W'(MS_PER_CENTIHOUR);
   localparam logic [FIX_W-1:0]   DIV2  = FIX_W'(2 * MS_PER_CENTIHOUR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SUM_W) / MS_PER_CENTIHOUR);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_FIX  = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_DEC  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   pllc_item_type         item_ff, item_in;
   logic [SUM_W-1:0]      sum_ff [NUM_PUMPS];
   logic [SUM_W-1:0]      sum_in [NUM_PUMPS];
   logic [SUM_W-1:0]      qest_ff [NUM_PUMPS];
   logic [SUM_W-1:0]      qest_in [NUM_PUMPS];
   logic [FIX_W-1:0]      rraw_ff [NUM_PUMPS];
   logic [FIX_W-1:0]      rraw_in [NUM_PUMPS];
   logic [REM_W-1:0]      rem_ff [NUM_PUMPS];
   logic [REM_W-1:0]      rem_in [NUM_PUMPS];
   logic [HOUR_W-1:0]     hour_ff [NUM_PUMPS];
   logic [HOUR_W-1:0]     hour_in [NUM_PUMPS];
   logic [HOUR_W-1:0]     act_hours_ff, act_hours_in;
   logic [1:0]            sel_ff, sel_in;
   logic [2:0]            mode_ff, mode_in;
   logic [1:0]            sent_ff [NUM_PUMPS];
   logic [1:0]            sent_in [NUM_PUMPS];
   logic [NUM_PUMPS-1:0]  want_ff, want_in;
   logic [NUM_PUMPS-1:0]  pend_ff, pend_in;
   logic                  rem_ok;
   logic                  fix_ok;

   always_comb begin
      logic [PROD_W-1:0]    prod;
      logic                 corr;
      logic [SUM_W-1:0]     q;
      logic [1:0]           sel;
      logic [2:0]           mode;
      logic [NUM_PUMPS-1:0] want;
      logic [NUM_PUMPS-1:0] change;
      logic [1:0]           cmd;
      logic [1:0]           pick;
      logic [NUM_PUMPS-1:0] rest;

      state_in     = state_ff;
      item_in      = item_ff;
      sum_in       = sum_ff;
      qest_in      = qest_ff;
      rraw_in      = rraw_ff;
      rem_in       = rem_ff;
      hour_in      = hour_ff;
      act_hours_in = act_hours_ff;
      sel_in       = sel_ff;
      mode_in      = mode_ff;
      sent_in      = sent_ff;
      want_in      = want_ff;
      pend_in      = pend_ff;
      item_pop     = 1'b0;
      rsp_push     = 1'b0;
      prod         = '0;
      corr         = 1'b0;
      q            = '0;
      sel          = sel_ff;
      mode         = mode_ff;
      want         = '0;
      change       = '0;
      cmd          = CMD_UNKNOWN;
      pick         = 2'd0;
      rest         = pend_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.is_mode) begin
                  mode_in = item.mode_value;
               end else begin
                  item_in = item;
                  for (int i = 0; i < NUM_PUMPS; i++) begin
                     sum_in[i]  = SUM_W'(rem_ff[i]) + SUM_W'(item.elapsed_ms);
                     prod       = PROD_W'(sum_in[i]) * PROD_W'(RECIP);
                     qest_in[i] = prod[SUM_W +: SUM_W];
                  end
                  state_in = ST_FIX;
               end
            end
         end
         ST_FIX: begin
            for (int i = 0; i < NUM_PUMPS; i++) begin
               rraw_in[i] = FIX_W'(sum_ff[i]) - FIX_W'(FIX_W'(qest_ff[i]) * DIV_X);
            end
            state_in = ST_ACC;
         end
         ST_ACC: begin
            for (int i = 0; i < NUM_PUMPS; i++) begin
               if (item_ff.running[i]) begin
                  corr       = (rraw_ff[i] >= DIV_X);
                  q          = qest_ff[i] + SUM_W'(corr);
                  rem_in[i]  = corr ? REM_W'(rraw_ff[i] - DIV_X) : REM_W'(rraw_ff[i]);
                  hour_in[i] = hour_ff[i] + HOUR_W'(q);
                  if ((sel_ff == 2'(i)) && item_ff.avail[i]) begin
                     act_hours_in = act_hours_ff + HOUR_W'(q);
                  end
               end
            end
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (sel == SEL_NONE) begin
               priority if (item_ff.avail[0] && item_ff.avail[2]) begin
                  sel = (hour_ff[0] <= hour_ff[2]) ? SEL_A : SEL_C;
               end else if (item_ff.avail[0]) begin
                  sel = SEL_A;
               end else if (item_ff.avail[2]) begin
                  sel = SEL_C;
               end else begin
                  sel = SEL_NONE;
               end
            end
            if (act_hours_ff > HOUR_W'(rot_limit)) begin
               if ((sel == SEL_A) && item_ff.avail[2]) begin
                  sel          = SEL_C;
                  act_hours_in = '0;
               end else if ((sel == SEL_C) && item_ff.avail[0]) begin
                  sel          = SEL_A;
                  act_hours_in = '0;
               end
            end
            if (((mode == MODE_SMALL) || (mode == MODE_BOTH)) &&
                !item_ff.avail[0] && !item_ff.avail[2]) begin
               mode = MODE_LARGE;
            end else if ((mode == MODE_LARGE) && !item_ff.avail[1]) begin
               mode = MODE_SMALL;
            end
            if (((mode == MODE_SMALL) || (mode == MODE_BOTH)) && (sel != SEL_NONE)) begin
               want[sel] = 1'b1;
            end
            if (((mode == MODE_LARGE) || (mode == MODE_BOTH)) && item_ff.avail[1]) begin
               want[1] = 1'b1;
            end
            if (mode == MODE_ALL) begin
               want = item_ff.avail;
            end
            for (int i = 0; i < NUM_PUMPS; i++) begin
               cmd        = want[i] ? CMD_RUN : CMD_STOP;
               change[i]  = (cmd != sent_ff[i]);
               sent_in[i] = cmd;
            end
            sel_in   = sel;
            mode_in  = mode;
            want_in  = want;
            pend_in  = change;
            state_in = (change != '0) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            priority if (pend_ff[0]) begin
               pick = 2'd0;
            end else if (pend_ff[1]) begin
               pick = 2'd1;
            end else begin
               pick = 2'd2;
            end
            rest       = pend_ff;
            rest[pick] = 1'b0;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               pend_in  = rest;
               if (rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_data.pump_id     = pick + 2'd1;
      rsp_data.run_cmd     = want_ff[pick];
      rsp_data.active_pump = sel_ff;
      rsp_data.mode_now    = mode_ff;
      rsp_data.last        = (rest == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         act_hours_ff <= '0;
         sel_ff       <= SEL_NONE;
         mode_ff      <= MODE_SMALL;
         pend_ff      <= '0;
         for (int i = 0; i < NUM_PUMPS; i++) begin
            rem_ff[i]  <= '0;
            hour_ff[i] <= '0;
            sent_ff[i] <= CMD_UNKNOWN;
         end
      end else begin
         state_ff     <= state_in;
         act_hours_ff <= act_hours_in;
         sel_ff       <= sel_in;
         mode_ff      <= mode_in;
         pend_ff      <= pend_in;
         rem_ff       <= rem_in;
         hour_ff      <= hour_in;
         sent_ff      <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      sum_ff  <= sum_in;
      qest_ff <= qest_in;
      rraw_ff <= rraw_in;
      want_ff <= want_in;
   end

   assign rem_ok = (rem_ff[0] < DIV) && (rem_ff[1] < DIV) && (rem_ff[2] < DIV);
   assign fix_ok = (rraw_ff[0] < DIV2) && (rraw_ff[1] < DIV2) && (rraw_ff[2] < DIV2);

   `PLLC_ASSERT(a_rem_below_div, clock, reset, rem_ok)
   `PLLC_ASSERT_IMPL(a_fix_range, clock, reset, state_ff == ST_ACC, fix_ok)
   `PLLC_ASSERT_IMPL(a_push_in_emit, clock, reset, rsp_push, state_ff == ST_EMIT)
   `PLLC_ASSERT_IMPL(a_emit_has_work, clock, reset, state_ff == ST_EMIT, pend_ff != '0)

endmodule

`default_nettype wire

@@ hdl/pump_lead_lag_controller_top.sv @@
// Channel   Ports                        Handshake
// request   push, full, req_payload      accepted on push && !full
// result    empty, pop, rsp_payload      taken on pop && !empty
// csr       psel, penable, pwrite, ...   written on psel && penable && pwrite
//
// A mode write request is taken in the back end's idle state. A tick passes the idle,
// fix, accumulate and decide states (metering by divide-by-reciprocal), then the emit
// state pushes one changed command per cycle while the result queue is not full.
// Requests and results wait in their own queues, so either side may stall.
// Reset is synchronous; no clearing pass follows.
// Top level of the pump lead/lag controller; depends on pllc_pkg, pllc_front,
// pllc_back and pllc_fifo.
`default_nettype none

module pump_lead_lag_controller_top
   import pllc_pkg::*;
#(
   parameter int MS_PER_CENTIHOUR = 36000,
   parameter int REQ_DEPTH        = 4,
   parameter int RSP_DEPTH        = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire pllc_req_type           req_payload,
   output logic                        empty,
   input  wire logic                   pop,
   output pllc_rsp_type                rsp_payload,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_W-1:0]       pwdata,
   output logic      [CSR_W-1:0]       prdata,
   output logic                        pready
);

   localparam int RSP_W = $bits(pllc_rsp_type);

   logic [LIMIT_W-1:0] rot_limit_ff, rot_limit_in;
   logic               csr_write;
   logic               item_valid;
   pllc_item_type      item;
   logic               item_pop;
   logic               rsp_push;
   pllc_rsp_type       rsp_data;
   logic               rsp_full;
   logic [RSP_W-1:0]   rsp_bits;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[CSR_ADDR_W-1] == CSR_ROT_LIMIT);

   always_comb begin
      rot_limit_in = rot_limit_ff;
      if (csr_write) begin
         rot_limit_in = pwdata[LIMIT_W-1:0];
      end
      prdata = '0;
      if (paddr[CSR_ADDR_W-1] == CSR_ROT_LIMIT) begin
         prdata = CSR_W'(rot_limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_limit_ff <= ROT_LIMIT_RESET;
      end else begin
         rot_limit_ff <= rot_limit_in;
      end
   end

   pllc_front #(
      .DEPTH (REQ_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop)
   );

   pllc_back #(
      .MS_PER_CENTIHOUR (MS_PER_CENTIHOUR)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .rot_limit  (rot_limit_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_data),
      .rsp_full   (rsp_full)
   );

   pllc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_data),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_bits),
      .empty   (empty)
   );

   assign rsp_payload = pllc_rsp_type'(rsp_bits);

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the pump lead/lag controller: drives ticks, mode writes
// and rotation limit writes with read-back, predicts every pump command and checks it
// against the result queue. Depends on pllc_pkg and pump_lead_lag_controller_top.
`default_nettype none

module tb;
   import pllc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MS_PER_CENTIHOUR = 36000;
   localparam int PUMP_A = 0;
   localparam int PUMP_B = 1;
   localparam int PUMP_C = 2;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [CSR_ADDR_W-1:0] ROT_LIMIT_ADDR = CSR_ADDR_W'(4 * CSR_ROT_LIMIT);

   class pump_command_tracker;
      logic [15:0] rot_limit;
      logic [31:0] ms_left[3];
      logic [31:0] hours[3];
      logic [31:0] active_hours;
      logic [1:0]  active_sel;
      logic [2:0]  mode;
      logic [1:0]  last_cmd[3];
      pllc_rsp_type pending[$];
      int errors, ticks, mode_writes, checked, rotations;

      function void clear_state();
         rot_limit = ROT_LIMIT_RESET;
         for (int i = 0; i < NUM_PUMPS; i++) begin
            ms_left[i] = '0;
            hours[i] = '0;
            last_cmd[i] = CMD_UNKNOWN;
         end
         active_hours = '0;
         active_sel = SEL_NONE;
         mode = MODE_SMALL;
         pending.delete();
      endfunction

      function void note_request(pllc_req_type r);
         logic [15:0] status[3];
         logic        auto_flag[3];
         logic        avail[3];
         logic        want[3];
         logic        online, running;
         logic [31:0] sum, whole;
         logic [1:0]  cmd;
         pllc_rsp_type c;
         pllc_rsp_type batch[$];
         if (r.req_type == REQ_MODE) begin
            mode = r.mode_value;
            mode_writes++;
            return;
         end
         ticks++;
         status = '{r.status_a, r.status_b, r.status_c};
         auto_flag = '{r.auto_a, r.auto_b, r.auto_c};
         for (int i = 0; i < NUM_PUMPS; i++) begin
            online = status[i] >= STAT_RUN_FWD && status[i] <= STAT_STOPPED;
            running = status[i] == STAT_RUN_FWD || status[i] == STAT_RUN_REV;
            avail[i] = auto_flag[i] && online;
            if (running) begin
               sum = ms_left[i] + 32'(r.elapsed_ms);
               whole = sum / MS_PER_CENTIHOUR;
               hours[i] += whole;
               if (i == int'(active_sel) && avail[i]) active_hours += whole;
               ms_left[i] = sum % MS_PER_CENTIHOUR;
            end
         end
         if (active_sel == SEL_NONE) begin
            if (avail[PUMP_A] && avail[PUMP_C])
               active_sel = (hours[PUMP_A] <= hours[PUMP_C]) ? SEL_A : SEL_C;
            else if (avail[PUMP_A])
               active_sel = SEL_A;
            else if (avail[PUMP_C])
               active_sel = SEL_C;
         end
         if (active_hours > 32'(rot_limit)) begin
            if (active_sel == SEL_A && avail[PUMP_C]) begin
               active_sel = SEL_C;
               active_hours = '0;
               rotations++;
            end else if (active_sel == SEL_C && avail[PUMP_A]) begin
               active_sel = SEL_A;
               active_hours = '0;
               rotations++;
            end
         end
         if ((mode == MODE_SMALL || mode == MODE_BOTH) && !avail[PUMP_A] && !avail[PUMP_C])
            mode = MODE_LARGE;
         else if (mode == MODE_LARGE && !avail[PUMP_B])
            mode = MODE_SMALL;
         want = '{1'b0, 1'b0, 1'b0};
         if ((mode == MODE_SMALL || mode == MODE_BOTH) && active_sel != SEL_NONE)
            want[active_sel] = 1'b1;
         if ((mode == MODE_LARGE || mode == MODE_BOTH) && avail[PUMP_B])
            want[PUMP_B] = 1'b1;
         if (mode == MODE_ALL)
            want = avail;
         for (int i = 0; i < NUM_PUMPS; i++) begin
            cmd = want[i] ? CMD_RUN : CMD_STOP;
            if (cmd != last_cmd[i]) begin
               last_cmd[i] = cmd;
               c.pump_id = 2'(i + 1);
               c.run_cmd = want[i];
               c.active_pump = active_sel;
               c.mode_now = mode;
               c.last = 1'b0;
               batch.push_back(c);
            end
         end
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[k]) pending.push_back(batch[k]);
      endfunction

      function void check_command(pllc_rsp_type got);
         pllc_rsp_type exp;
         if (pending.size() == 0) begin
            $error("unexpected pump command %p", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got.pump_id !== exp.pump_id) begin
            $error("pump_id: expected %0d, got %0d", exp.pump_id, got.pump_id);
            errors++;
         end
         if (got.run_cmd !== exp.run_cmd) begin
            $error("run_cmd: expected %0d, got %0d", exp.run_cmd, got.run_cmd);
            errors++;
         end
         if (got.active_pump !== exp.active_pump) begin
            $error("active_pump: expected %0d, got %0d", exp.active_pump, got.active_pump);
            errors++;
         end
         if (got.mode_now !== exp.mode_now) begin
            $error("mode_now: expected %0d, got %0d", exp.mode_now, got.mode_now);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   pllc_req_type req_payload = '0;
   logic empty;
   logic pop = 1'b0;
   pllc_rsp_type rsp_payload;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_W-1:0] pwdata = '0;
   logic [CSR_W-1:0] prdata;
   logic pready;

   pump_command_tracker tracker;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;

   pump_lead_lag_controller_top #(.MS_PER_CENTIHOUR(MS_PER_CENTIHOUR)) i_dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_payload(req_payload),
      .empty(empty), .pop(pop), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   initial begin
      #3_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            pop = 1'b0;
            hold_cycles--;
         end else begin
            pop = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) tracker.check_command(rsp_payload);
   end

   function automatic logic [15:0] pick_status();
      case ($urandom_range(11))
         0, 1, 2: return STAT_RUN_FWD;
         3, 4:    return STAT_RUN_REV;
         5, 6, 7: return STAT_STOPPED;
         8:       return '0;
         9:       return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pllc_req_type make_tick(logic [19:0] ms, logic [15:0] sa, logic [15:0] sb,
                                              logic [15:0] sc, logic aa, logic ab, logic ac);
      pllc_req_type r;
      r = '0;
      r.req_type = REQ_TICK;
      r.elapsed_ms = ms;
      r.status_a = sa;
      r.status_b = sb;
      r.status_c = sc;
      r.auto_a = aa;
      r.auto_b = ab;
      r.auto_c = ac;
      return r;
   endfunction

   function automatic pllc_req_type make_mode(logic [2:0] m);
      pllc_req_type r;
      r = '0;
      r.req_type = REQ_MODE;
      r.mode_value = m;
      return r;
   endfunction

   function automatic pllc_req_type random_request();
      pllc_req_type r;
      r.req_type = ($urandom_range(99) < 15) ? REQ_MODE : REQ_TICK;
      case ($urandom_range(9))
         0:       r.elapsed_ms = $urandom_range(1) ? '1 : '0;
         1, 2:    r.elapsed_ms = 20'($urandom_range(40000));
         default: r.elapsed_ms = 20'($urandom_range(20'hFFFFF));
      endcase
      r.status_a = pick_status();
      r.status_b = pick_status();
      r.status_c = pick_status();
      r.auto_a = ($urandom_range(9) != 0);
      r.auto_b = ($urandom_range(9) != 0);
      r.auto_c = ($urandom_range(9) != 0);
      r.mode_value = ($urandom_range(3) == 0) ? 3'($urandom_range(7))
                                               : 3'($urandom_range(MODE_SMALL, MODE_ALL));
      return r;
   endfunction

   task automatic send_request(pllc_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         push = 1'b0;
         @(negedge clock);
      end
      push = 1'b1;
      req_payload = r;
      do @(posedge clock); while (full);
      tracker.note_request(r);
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      push = 1'b0;
      while (tracker.pending.size() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_rotation_limit(logic [15:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = ROT_LIMIT_ADDR;
      pwdata = CSR_W'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      tracker.rot_limit = value;
      @(negedge clock);
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_W'(value)) begin
         $error("rotation_limit: expected %0d, got %0d", value, prdata);
         tracker.errors++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic run_random(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_request(random_request());
      wait_all_results();
   endtask

   initial begin
      tracker = new();
      tracker.clear_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(make_tick('0, STAT_STOPPED, STAT_STOPPED, STAT_STOPPED, 1'b1, 1'b1, 1'b1));
      send_request(make_tick('0, STAT_STOPPED, STAT_STOPPED, STAT_STOPPED, 1'b1, 1'b1, 1'b1));
      for (int v = 0; v < 8; v++) begin
         send_request(make_mode(3'(v)));
         send_request(make_tick('1, STAT_RUN_FWD, STAT_RUN_REV, STAT_STOPPED,
                                1'b1, v[0], 1'b1));
      end
      send_request(make_mode(MODE_LARGE));
      send_request(make_tick(20'd36000, STAT_RUN_FWD, '1, STAT_RUN_REV, 1'b1, 1'b1, 1'b1));
      send_request(make_mode(MODE_BOTH));
      send_request(make_tick(20'd1, '0, STAT_RUN_FWD, '1, 1'b1, 1'b1, 1'b1));
      send_request(make_tick(20'd35999, STAT_RUN_FWD, STAT_STOPPED, STAT_RUN_FWD,
                             1'b0, 1'b1, 1'b0));
      wait_all_results();

      write_rotation_limit('0);
      run_random(55, 0, 0);

      write_rotation_limit('1);
      run_random(28, 46, 0);
      run_random(27, 46, 0);

      write_rotation_limit(16'd3);
      hold_cycles = 200;
      run_random(55, 0, 46);

      write_rotation_limit(16'($urandom_range(1, 65534)));
      run_random(55, 32, 32);

      write_rotation_limit(ROT_LIMIT_RESET);
      run_random(20, 0, 0);

      $display("Run covered %0d ticks, %0d mode writes and %0d small-pump rotations;",
               tracker.ticks, tracker.mode_writes, tracker.rotations);
      $display("%0d pump commands were checked across six rotation limit settings.",
               tracker.checked);
      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ pump_lead_lag_controller_top.f @@
+incdir+hdl
hdl/pllc_pkg.sv
hdl/pllc_fifo.sv
hdl/pllc_front.sv
hdl/pllc_back.sv
hdl/pump_lead_lag_controller_top.sv
bench/tb.sv
